>>> rtl/core/heat_diffusion_stencil_2d_defines.svh
// assertion macros shared by the checker of the heat diffusion stencil
// needs a clock named clk_i and an active-low reset named rst_ni in scope
`ifndef HEAT_DIFFUSION_STENCIL_2D_DEFINES_SVH
`define HEAT_DIFFUSION_STENCIL_2D_DEFINES_SVH

// same-cycle implication
`define HDS_ASSERT_IMP(label, ant, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HDS_ASSERT_NXT(label, ant, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/hds_pkg.sv
// shared types and constants of the heat diffusion stencil block
// no dependencies
package hds_pkg;

  localparam int MaxCols  = 32;
  localparam int ColW     = $clog2(MaxCols);      // column counter
  localparam int ColsW    = ColW + 1;             // column count, holds MaxCols
  localparam int RowW     = 10;                   // row counter
  localparam int RowsW    = 11;                   // row count register
  localparam int StoreAw  = $clog2(2 * MaxCols);  // two line stores
  localparam int CoeffW   = 23;
  localparam int TempW    = 32;
  localparam int SumW     = TempW + 3;
  localparam int ProdW    = SumW + CoeffW + 1;
  localparam int FracW    = 24;
  localparam int PaddrW   = 4;
  localparam int PdataW   = 32;

  localparam logic [RowsW-1:0] RowsMin = RowsW'(3);
  localparam logic [RowsW-1:0] RowsMax = RowsW'(1024);
  localparam logic [ColsW-1:0] ColsMin = ColsW'(3);
  localparam logic [ColsW-1:0] ColsMax = ColsW'(MaxCols);

  localparam logic [CoeffW-1:0] CoeffReset = CoeffW'(1678);
  localparam logic [RowsW-1:0]  RowsReset  = RowsW'(32);
  localparam logic [ColsW-1:0]  ColsReset  = ColsW'(32);

  typedef enum logic [1:0] {
    RegCoeff = 2'd0,
    RegRows  = 2'd1,
    RegCols  = 2'd2
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_RIGHT,
    S_SUM,
    S_MUL,
    S_RES,
    S_OUT,
    S_WRITE,
    S_FRD,
    S_FLD,
    S_FOUT
  } state_e;

  typedef struct packed {
    logic [CoeffW-1:0] coeff;
    logic [RowsW-1:0]  rows;
    logic [ColsW-1:0]  cols;
    logic              geom_wr;
  } cfg_t;

  typedef struct packed {
    logic cap_in;
    logic rd_ctr;
    logic rd_right;
    logic calc_sum;
    logic calc_mul;
    logic load_res;
    logic wr_store;
    logic advance;
    logic flush_rd;
    logic load_flush;
    logic flush_inc;
  } ctrl_cmd_t;

  typedef struct packed {
    logic has_out;
    logic frame_end;
    logic flush_last;
  } dp_status_t;

endpackage

>>> rtl/core/hds_regs.sv
// apb register file: diffusion coefficient and grid geometry
// depends on hds_pkg
module hds_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hds_pkg::PaddrW-1:0] paddr,
  input  logic [hds_pkg::PdataW-1:0] pwdata,
  output logic [hds_pkg::PdataW-1:0] prdata,
  output logic                       pready,
  output hds_pkg::cfg_t              cfg_o
);
  import hds_pkg::*;

  logic [CoeffW-1:0] coeff_q, coeff_d;
  logic [RowsW-1:0]  rows_q, rows_d;
  logic [ColsW-1:0]  cols_q, cols_d;
  logic              wr_en;
  reg_idx_e          idx;
  logic              geom_wr;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);

  always_comb begin
    coeff_d = coeff_q;
    rows_d  = rows_q;
    cols_d  = cols_q;
    geom_wr = 1'b0;
    if (wr_en) begin
      unique case (idx)
        RegCoeff: coeff_d = pwdata[CoeffW-1:0];
        RegRows: begin
          rows_d  = pwdata[RowsW-1:0];
          geom_wr = 1'b1;
        end
        RegCols: begin
          cols_d  = pwdata[ColsW-1:0];
          geom_wr = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q <= CoeffReset;
      rows_q  <= RowsReset;
      cols_q  <= ColsReset;
    end else begin
      coeff_q <= coeff_d;
      rows_q  <= rows_d;
      cols_q  <= cols_d;
    end
  end

  always_comb begin
    unique case (idx)
      RegCoeff: prdata = PdataW'(coeff_q);
      RegRows:  prdata = PdataW'(rows_q);
      RegCols:  prdata = PdataW'(cols_q);
      default:  prdata = '0;
    endcase
  end

  assign cfg_o = '{coeff: coeff_q, rows: rows_q, cols: cols_q, geom_wr: geom_wr};

endmodule

>>> rtl/core/hds_ctrl.sv
// sequencer of the stencil: steps requests through read, compute, output, write
// first-row requests only write, the frame end flushes; depends on hds_pkg
module hds_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cell_valid_i,
  output logic                cell_ready_o,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  input  hds_pkg::dp_status_t status_i,
  output hds_pkg::ctrl_cmd_t  cmd_o
);
  import hds_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cell_valid_i) begin
          state_d = status_i.has_out ? S_READ : S_WRITE;
        end
      end
      S_READ:  state_d = S_RIGHT;
      S_RIGHT: state_d = S_SUM;
      S_SUM:   state_d = S_MUL;
      S_MUL:   state_d = S_RES;
      S_RES:   state_d = S_OUT;
      S_OUT: begin
        if (res_ready_i) state_d = S_WRITE;
      end
      S_WRITE: state_d = status_i.frame_end ? S_FRD : S_IDLE;
      S_FRD:   state_d = S_FLD;
      S_FLD:   state_d = S_FOUT;
      S_FOUT: begin
        if (res_ready_i) begin
          state_d = status_i.flush_last ? S_IDLE : S_FRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cell_ready_o = 1'b0;
    res_valid_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        cell_ready_o = 1'b1;
        cmd_o.cap_in = cell_valid_i;
      end
      S_READ:  cmd_o.rd_ctr   = 1'b1;
      S_RIGHT: cmd_o.rd_right = 1'b1;
      S_SUM:   cmd_o.calc_sum = 1'b1;
      S_MUL:   cmd_o.calc_mul = 1'b1;
      S_RES:   cmd_o.load_res = 1'b1;
      S_OUT:   res_valid_o    = 1'b1;
      S_WRITE: begin
        cmd_o.wr_store = 1'b1;
        // at frame end the counters move only once the last row is flushed
        cmd_o.advance  = !status_i.frame_end;
      end
      S_FRD: cmd_o.flush_rd   = 1'b1;
      S_FLD: cmd_o.load_flush = 1'b1;
      S_FOUT: begin
        res_valid_o     = 1'b1;
        cmd_o.flush_inc = res_ready_i & !status_i.flush_last;
        cmd_o.advance   = res_ready_i & status_i.flush_last;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/core/hds_datapath.sv
// datapath of the stencil: line store memory, position counters,
// five-point sum, coefficient multiply, rounding and saturation
// depends on hds_pkg
module hds_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic signed [hds_pkg::TempW-1:0]  cell_temp_i,
  input  hds_pkg::cfg_t                     cfg_i,
  input  hds_pkg::ctrl_cmd_t                cmd_i,
  output hds_pkg::dp_status_t               status_o,
  output logic signed [hds_pkg::TempW-1:0]  new_temp_o,
  output logic                              frame_last_o
);
  import hds_pkg::*;

  // position of the next input and flush column
  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] col_q, col_d;
  logic [ColW-1:0] fl_q, fl_d;

  logic [RowsW-1:0] eff_rows;
  logic [ColsW-1:0] eff_cols;
  logic             last_col, last_row, interior;

  // line stores, indexed by row parity
  logic [TempW-1:0]   mem [2*MaxCols];
  logic [TempW-1:0]   rd0_q, rd1_q;
  logic [StoreAw-1:0] cur_base, prev_base, raddr0, waddr;
  logic               rd0_en;

  logic signed [TempW-1:0] tin_q, center_q, up_q, left_q;
  logic signed [SumW-1:0]  sum_q, sum_d;
  logic signed [ProdW-1:0] prod_q, prod_d, rnd;
  logic signed [SumW-1:0]  delta;
  logic signed [TempW+3:0] upd;
  logic signed [TempW-1:0] sat;
  logic signed [TempW-1:0] out_q;
  logic                    last_q;

  always_comb begin
    if (cfg_i.rows < RowsMin)      eff_rows = RowsMin;
    else if (cfg_i.rows > RowsMax) eff_rows = RowsMax;
    else                           eff_rows = cfg_i.rows;
    if (cfg_i.cols < ColsMin)      eff_cols = ColsMin;
    else if (cfg_i.cols > ColsMax) eff_cols = ColsMax;
    else                           eff_cols = cfg_i.cols;
  end

  assign last_col = (ColsW'(col_q) + ColsW'(1)) >= eff_cols;
  assign last_row = (RowsW'(row_q) + RowsW'(1)) >= eff_rows;
  // output row is row_q - 1, never the bottom border
  assign interior = (row_q >= RowW'(2)) && (col_q != '0)
                 && ((ColsW'(col_q) + ColsW'(2)) <= eff_cols);

  assign status_o = '{has_out:    (row_q != '0),
                      frame_end:  last_col & last_row,
                      flush_last: (ColsW'(fl_q) + ColsW'(1)) == eff_cols};

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    fl_d  = fl_q;
    if (cmd_i.advance) begin
      fl_d = '0;
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end else if (cmd_i.flush_inc) begin
      fl_d = fl_q + ColW'(1);
    end
    if (cfg_i.geom_wr) begin
      row_d = '0;
      col_d = '0;
      fl_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      fl_q   <= '0;
      left_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
      fl_q  <= fl_d;
      if (cmd_i.calc_sum) left_q <= center_q;
    end
  end

  assign cur_base  = row_q[0] ? StoreAw'(MaxCols) : '0;
  assign prev_base = row_q[0] ? '0 : StoreAw'(MaxCols);
  assign waddr     = cur_base + StoreAw'(col_q);
  assign rd0_en    = cmd_i.rd_ctr | cmd_i.rd_right | cmd_i.flush_rd;

  always_comb begin
    if (cmd_i.rd_right)      raddr0 = prev_base + StoreAw'(col_q) + StoreAw'(1);
    else if (cmd_i.flush_rd) raddr0 = cur_base + StoreAw'(fl_q);
    else                     raddr0 = prev_base + StoreAw'(col_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_store) mem[waddr] <= tin_q;
    if (rd0_en)         rd0_q <= mem[raddr0];
    // up neighbor sits at the slot this input will overwrite
    if (cmd_i.rd_ctr)   rd1_q <= mem[waddr];
  end

  always_comb begin
    sum_d = SumW'(up_q) + SumW'(tin_q) + SumW'(left_q) + SumW'($signed(rd0_q))
          - (SumW'(center_q) <<< 2);
    prod_d = ProdW'(sum_q) * ProdW'($signed({1'b0, cfg_i.coeff}));
    // round to nearest, ties toward plus infinity
    rnd   = prod_q + ProdW'(1 <<< (FracW - 1));
    delta = rnd[ProdW-1:FracW];
    upd   = (TempW+4)'(center_q) + (TempW+4)'(delta);
    if (upd > (TempW+4)'(signed'({1'b0, {(TempW-1){1'b1}}}))) begin
      sat = {1'b0, {(TempW-1){1'b1}}};
    end else if (upd < (TempW+4)'(signed'({1'b1, {(TempW-1){1'b0}}}))) begin
      sat = {1'b1, {(TempW-1){1'b0}}};
    end else begin
      sat = upd[TempW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) tin_q <= cell_temp_i;
    if (cmd_i.rd_right) begin
      center_q <= rd0_q;
      up_q     <= rd1_q;
    end
    if (cmd_i.calc_sum) sum_q  <= sum_d;
    if (cmd_i.calc_mul) prod_q <= prod_d;
    if (cmd_i.load_res) begin
      out_q  <= interior ? sat : center_q;
      last_q <= 1'b0;
    end else if (cmd_i.load_flush) begin
      out_q  <= rd0_q;
      last_q <= status_o.flush_last;
    end
  end

  assign new_temp_o   = out_q;
  assign frame_last_o = last_q;

endmodule

>>> rtl/core/heat_diffusion_stencil_2d.sv
// One explicit heat-diffusion step over a grid streamed in raster order (five-point
// stencil, signed Q16.16 cells, Q0.24 coefficient, saturated result). Each result comes
// one row late; the last cell of a frame also flushes the whole last row, with
// frame_last on its final cell. A cell of the first row gives no result and goes
// straight to the store write; any other cell passes through the line store reads
// (center and up, then right), the sum, multiply and rounding stages, the wait for the
// result to be taken and the store write. Each flushed result is read, loaded and
// presented, then waits to be taken. Line store contents are undefined after reset and
// need no clearing pass: a frame uses only entries it wrote itself. Writing the row or
// column count restarts the frame.
module heat_diffusion_stencil_2d (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cell_valid_i,
  output logic                              cell_ready_o,
  input  logic signed [hds_pkg::TempW-1:0]  cell_temp_i,
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output logic signed [hds_pkg::TempW-1:0]  new_temp_o,
  output logic                              frame_last_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hds_pkg::PaddrW-1:0]        paddr,
  input  logic [hds_pkg::PdataW-1:0]        pwdata,
  output logic [hds_pkg::PdataW-1:0]        prdata,
  output logic                              pready
);
  import hds_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  hds_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hds_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cell_valid_i (cell_valid_i),
    .cell_ready_o (cell_ready_o),
    .res_valid_o  (res_valid_o),
    .res_ready_i  (res_ready_i),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  hds_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cell_temp_i  (cell_temp_i),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .status_o     (status),
    .new_temp_o   (new_temp_o),
    .frame_last_o (frame_last_o)
  );

endmodule

>>> rtl/core/hds_checker.sv
// port-level checks of the heat diffusion stencil, bound to the top level
// depends on hds_pkg and heat_diffusion_stencil_2d_defines.svh
`include "heat_diffusion_stencil_2d_defines.svh"

module hds_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              cell_valid_i,
  input logic                              cell_ready_o,
  input logic                              res_valid_o,
  input logic                              res_ready_i,
  input logic signed [hds_pkg::TempW-1:0]  new_temp_o,
  input logic                              frame_last_o
);

  // a pending result holds until taken
  `HDS_ASSERT_NXT(a_res_hold, res_valid_o && !res_ready_i, res_valid_o && $stable(new_temp_o) && $stable(frame_last_o), "result changed while stalled")

  // one request in flight: no input taken while a result is shown
  `HDS_ASSERT_IMP(a_no_overlap, res_valid_o, !cell_ready_o, "input ready while result pending")

  // an accepted request occupies the block for the next cycle
  `HDS_ASSERT_NXT(a_busy_after_in, cell_valid_i && cell_ready_o, !cell_ready_o && !res_valid_o, "block not busy after request")

  // end of frame returns straight to idle
  `HDS_ASSERT_NXT(a_idle_after_last, res_valid_o && res_ready_i && frame_last_o, cell_ready_o, "not ready after frame end")

endmodule

bind heat_diffusion_stencil_2d hds_checker u_hds_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cell_valid_i (cell_valid_i),
  .cell_ready_o (cell_ready_o),
  .res_valid_o  (res_valid_o),
  .res_ready_i  (res_ready_i),
  .new_temp_o   (new_temp_o),
  .frame_last_o (frame_last_o)
);
